FILE: rtl/core/bhcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhcr_pkg
// Widths, transaction types and pipeline types for the chord reflection block.
// ----------------------------------------------------------------------------
package bhcr_pkg;

  localparam int COORD_BITS = 32;
  localparam int LANES      = 6;                  // 3 axes for each of 2 handles
  localparam int DW         = COORD_BITS + 1;     // chord / offset component
  localparam int PW         = 2 * DW;             // one product
  localparam int NW         = PW + 2;             // sum of three products
  localparam int HALF       = NW / 2;             // split point for n * d
  localparam int DEN_W      = 2 * COORD_BITS + 2; // d.d, unsigned
  localparam int NUM_W      = NW + DW + 1;        // 2 * n * d_i
  localparam int QB         = COORD_BITS + 3;     // quotient magnitude bits
  localparam int VW         = QB + 1;             // signed quotient / sum

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t start_handle_x;
    coord_t start_handle_y;
    coord_t start_handle_z;
    coord_t end_handle_x;
    coord_t end_handle_y;
    coord_t end_handle_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } seg_in_t;

  typedef struct packed {
    coord_t new_start_handle_x;
    coord_t new_start_handle_y;
    coord_t new_start_handle_z;
    coord_t new_end_handle_x;
    coord_t new_end_handle_y;
    coord_t new_end_handle_z;
    logic   degenerate;
    logic   clipped;
  } seg_out_t;

  // one stage of the restoring divider, all lanes side by side
  typedef struct packed {
    logic                                vld;
    logic                                same;
    logic [DEN_W-1:0]                    den;
    logic [LANES-1:0]                    neg;
    logic [LANES-1:0][DEN_W-1:0]         rem;
    logic [LANES-1:0][QB-1:0]            quo;
    logic [LANES-1:0][COORD_BITS-1:0]    anc;
    logic [LANES-1:0][COORD_BITS-1:0]    hnd;
  } div_stage_t;

endpackage

FILE: rtl/core/bezier_handle_chord_reflect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_handle_chord_reflect
// Mirrors both handles of a 3D cubic segment across its chord, saturating.
// ----------------------------------------------------------------------------
//  channel   ports                     transfer
//  input     start, busy, in_data      start && !busy at clk edge
//  result    out_valid, out_data       one cycle strobe, always taken
//
//  one segment per cycle; busy is held low since nothing can stall
//  the restoring divider makes one quotient bit per stage, six lanes in parallel
//  rst_n (synchronous) clears only the stage valid bits
//  degenerate segments flow through the same stages and bypass at the end
module bezier_handle_chord_reflect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bhcr_pkg::seg_in_t  in_data,
  output logic               out_valid,
  output bhcr_pkg::seg_out_t out_data
);
  import bhcr_pkg::*;

  typedef logic [LANES-1:0][COORD_BITS-1:0] lane_coord_t;

  assign busy = 1'b0;

  // ---------------- stage 1: differences ----------------
  logic                s1_vld_r, s1_same_r;
  logic [2:0][DW-1:0]  s1_d_r, s1_ua_r, s1_ub_r;
  lane_coord_t         s1_anc_r, s1_hnd_r;
  logic [2:0][DW-1:0]  s1_d_nxt, s1_ua_nxt, s1_ub_nxt;
  lane_coord_t         s1_anc_nxt, s1_hnd_nxt;
  logic                s1_same_nxt;

  always_comb begin
    coord_t s [3];
    coord_t a [3];
    coord_t b [3];
    coord_t e [3];
    s[0] = in_data.start_x;        s[1] = in_data.start_y;        s[2] = in_data.start_z;
    a[0] = in_data.start_handle_x; a[1] = in_data.start_handle_y; a[2] = in_data.start_handle_z;
    b[0] = in_data.end_handle_x;   b[1] = in_data.end_handle_y;   b[2] = in_data.end_handle_z;
    e[0] = in_data.end_x;          e[1] = in_data.end_y;          e[2] = in_data.end_z;
    s1_same_nxt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      s1_d_nxt[i]       = DW'(e[i]) - DW'(s[i]);
      s1_ua_nxt[i]      = DW'(a[i]) - DW'(s[i]);
      s1_ub_nxt[i]      = DW'(b[i]) - DW'(e[i]);
      s1_anc_nxt[i]     = s[i];
      s1_anc_nxt[3 + i] = e[i];
      s1_hnd_nxt[i]     = a[i];
      s1_hnd_nxt[3 + i] = b[i];
      if (s[i] != e[i]) s1_same_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
    s1_same_r <= s1_same_nxt;
    s1_d_r    <= s1_d_nxt;
    s1_ua_r   <= s1_ua_nxt;
    s1_ub_r   <= s1_ub_nxt;
    s1_anc_r  <= s1_anc_nxt;
    s1_hnd_r  <= s1_hnd_nxt;
  end

  // ---------------- stage 2: component products ----------------
  logic                s2_vld_r, s2_same_r;
  logic [2:0][PW-1:0]  s2_pd_r, s2_pa_r, s2_pb_r;
  logic [2:0][DW-1:0]  s2_d_r;
  lane_coord_t         s2_anc_r, s2_hnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    for (int i = 0; i < 3; i++) begin
      s2_pd_r[i] <= PW'($signed(s1_d_r[i]) * $signed(s1_d_r[i]));
      s2_pa_r[i] <= PW'($signed(s1_d_r[i]) * $signed(s1_ua_r[i]));
      s2_pb_r[i] <= PW'($signed(s1_d_r[i]) * $signed(s1_ub_r[i]));
    end
    s2_same_r <= s1_same_r;
    s2_d_r    <= s1_d_r;
    s2_anc_r  <= s1_anc_r;
    s2_hnd_r  <= s1_hnd_r;
  end

  // ---------------- stage 3: dot products ----------------
  logic                s3_vld_r, s3_same_r;
  logic [DEN_W-1:0]    s3_den_r;
  logic [1:0][NW-1:0]  s3_n_r;
  logic [2:0][DW-1:0]  s3_d_r;
  lane_coord_t         s3_anc_r, s3_hnd_r;
  logic signed [NW-1:0] s3_den_sum, s3_na_sum, s3_nb_sum;

  always_comb begin
    s3_den_sum = '0;
    s3_na_sum  = '0;
    s3_nb_sum  = '0;
    for (int i = 0; i < 3; i++) begin
      s3_den_sum = s3_den_sum + NW'($signed(s2_pd_r[i]));
      s3_na_sum  = s3_na_sum  + NW'($signed(s2_pa_r[i]));
      s3_nb_sum  = s3_nb_sum  + NW'($signed(s2_pb_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_den_r  <= s3_den_sum[DEN_W-1:0];
    s3_n_r[0] <= s3_na_sum;
    s3_n_r[1] <= s3_nb_sum;
    s3_same_r <= s2_same_r;
    s3_d_r    <= s2_d_r;
    s3_anc_r  <= s2_anc_r;
    s3_hnd_r  <= s2_hnd_r;
  end

  // ---------------- stage 4: split products n * d_i ----------------
  logic                              s4_vld_r, s4_same_r;
  logic [DEN_W-1:0]                  s4_den_r;
  logic [LANES-1:0][HALF+DW-1:0]     s4_hi_r;
  logic [LANES-1:0][HALF+DW:0]       s4_lo_r;
  lane_coord_t                       s4_anc_r, s4_hnd_r;

  for (genvar j = 0; j < LANES; j++) begin : g_s4
    always_ff @(posedge clk) begin
      s4_hi_r[j] <= (HALF + DW)'($signed(s3_n_r[j / 3][NW-1:HALF]) *
                                $signed(s3_d_r[j % 3]));
      s4_lo_r[j] <= (HALF + DW + 1)'($signed({1'b0, s3_n_r[j / 3][HALF-1:0]}) *
                                    $signed(s3_d_r[j % 3]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
    s4_same_r <= s3_same_r;
    s4_den_r  <= s3_den_r;
    s4_anc_r  <= s3_anc_r;
    s4_hnd_r  <= s3_hnd_r;
  end

  // ---------------- stage 5: combine to 2 * n * d_i ----------------
  logic                         s5_vld_r, s5_same_r;
  logic [DEN_W-1:0]             s5_den_r;
  logic [LANES-1:0][NUM_W-1:0]  s5_num_r;
  lane_coord_t                  s5_anc_r, s5_hnd_r;

  for (genvar j = 0; j < LANES; j++) begin : g_s5
    logic signed [NUM_W-1:0] hi_ext, lo_ext;
    assign hi_ext = NUM_W'($signed(s4_hi_r[j]));
    assign lo_ext = NUM_W'($signed(s4_lo_r[j]));
    always_ff @(posedge clk) begin
      s5_num_r[j] <= ((hi_ext <<< HALF) + lo_ext) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
    s5_same_r <= s4_same_r;
    s5_den_r  <= s4_den_r;
    s5_anc_r  <= s4_anc_r;
    s5_hnd_r  <= s4_hnd_r;
  end

  // ---------------- stage 6: magnitude, divider load ----------------
  div_stage_t div_r [QB+1];
  div_stage_t div0_nxt;

  always_comb begin
    logic [NUM_W-1:0] mag;
    div0_nxt      = '0;
    div0_nxt.vld  = s5_vld_r;
    div0_nxt.same = s5_same_r;
    div0_nxt.den  = s5_den_r;
    div0_nxt.anc  = s5_anc_r;
    div0_nxt.hnd  = s5_hnd_r;
    for (int j = 0; j < LANES; j++) begin
      div0_nxt.neg[j] = s5_num_r[j][NUM_W-1];
      mag = div0_nxt.neg[j] ? (~s5_num_r[j] + NUM_W'(1)) : s5_num_r[j];
      // top part is below the divisor since the quotient fits in QB bits
      div0_nxt.rem[j] = mag[QB +: DEN_W];
      div0_nxt.quo[j] = mag[QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_r[0].vld <= 1'b0;
    else        div_r[0]     <= div0_nxt;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 1; k <= QB; k++) begin : g_div
    div_stage_t div_nxt;
    always_comb begin
      logic [DEN_W:0] trial, diff;
      div_nxt = div_r[k-1];
      for (int j = 0; j < LANES; j++) begin
        trial = {div_r[k-1].rem[j], div_r[k-1].quo[j][QB-1]};
        diff  = trial - {1'b0, div_r[k-1].den};
        if (trial >= {1'b0, div_r[k-1].den}) begin
          div_nxt.rem[j] = diff[DEN_W-1:0];
          div_nxt.quo[j] = {div_r[k-1].quo[j][QB-2:0], 1'b1};
        end else begin
          div_nxt.rem[j] = trial[DEN_W-1:0];
          div_nxt.quo[j] = {div_r[k-1].quo[j][QB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) div_r[k].vld <= 1'b0;
      else        div_r[k]     <= div_nxt;
    end
  end

  // ---------------- round: nearest, ties away from zero ----------------
  logic                      rd_vld_r, rd_same_r;
  logic [LANES-1:0][VW-1:0]  rd_q_r;
  lane_coord_t               rd_anc_r, rd_hnd_r;
  logic [LANES-1:0][VW-1:0]  rd_q_nxt;

  always_comb begin
    logic [VW-1:0] qm;
    for (int j = 0; j < LANES; j++) begin
      qm = {1'b0, div_r[QB].quo[j]};
      if ({div_r[QB].rem[j], 1'b0} >= {1'b0, div_r[QB].den}) qm = qm + VW'(1);
      rd_q_nxt[j] = div_r[QB].neg[j] ? (~qm + VW'(1)) : qm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= div_r[QB].vld;
    rd_same_r <= div_r[QB].same;
    rd_q_r    <= rd_q_nxt;
    rd_anc_r  <= div_r[QB].anc;
    rd_hnd_r  <= div_r[QB].hnd;
  end

  // ---------------- final: 2p - h + q, saturate; degenerate keeps h ----------------
  lane_coord_t res_nxt;
  logic        clip_nxt;

  always_comb begin
    logic signed [VW-1:0] pv, hv, v;
    logic                 in_range;
    clip_nxt = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      pv = VW'($signed(rd_anc_r[j]));
      hv = VW'($signed(rd_hnd_r[j]));
      v  = (pv <<< 1) - hv + $signed(rd_q_r[j]);
      in_range = (&v[VW-1:COORD_BITS-1]) || !(|v[VW-1:COORD_BITS-1]);
      if (rd_same_r) begin
        res_nxt[j] = rd_hnd_r[j];
      end else if (in_range) begin
        res_nxt[j] = v[COORD_BITS-1:0];
      end else begin
        clip_nxt   = 1'b1;
        res_nxt[j] = v[VW-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                             : {1'b0, {(COORD_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= rd_vld_r;
    out_data.new_start_handle_x <= res_nxt[0];
    out_data.new_start_handle_y <= res_nxt[1];
    out_data.new_start_handle_z <= res_nxt[2];
    out_data.new_end_handle_x   <= res_nxt[3];
    out_data.new_end_handle_y   <= res_nxt[4];
    out_data.new_end_handle_z   <= res_nxt[5];
    out_data.degenerate         <= rd_same_r;
    out_data.clipped            <= clip_nxt;
  end

endmodule
